FILE: design/htp_pkg.sv
`default_nettype none
package htp_pkg;

  // Field widths
  localparam int CAP_W      = 16;
  localparam int PPR_W      = 8;
  localparam int RLD_W      = 16;
  localparam int STALL_W    = 10;
  localparam int HZ_W       = 20;
  localparam int CNT_W      = 32;
  localparam int SPD_W      = 30;
  localparam int ANG_W      = 17;
  localparam int MS_W       = 10;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 20;

  // Shared restoring divider
  localparam int DIV_W   = 30;            // widest dividend (speed numerator)
  localparam int DEN_W   = CAP_W + PPR_W; // widest divisor (period * ppr)
  localparam int DCNT_W  = 5;
  localparam int ANUM_W  = 25;            // angle numerator width

  localparam logic [MS_W-1:0]    MS_MAX    = '1;
  localparam logic [ANUM_W-1:0]  ANG_SCALE = ANUM_W'(360 * 256);
  localparam logic [DIV_W-1:0]   SPD_SCALE = DIV_W'(60 * 16);

  localparam logic [PPR_W-1:0]   PPR_RST   = PPR_W'(1);
  localparam logic [RLD_W-1:0]   RLD_RST   = RLD_W'(65535);
  localparam logic [STALL_W-1:0] STALL_RST = STALL_W'(300);
  localparam logic [HZ_W-1:0]    HZ_RST    = HZ_W'(100000);

  localparam logic [CFG_IDX_W-1:0] CFG_PPR   = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] CFG_RLD   = CFG_IDX_W'(1);
  localparam logic [CFG_IDX_W-1:0] CFG_STALL = CFG_IDX_W'(2);
  localparam logic [CFG_IDX_W-1:0] CFG_HZ    = CFG_IDX_W'(3);

  localparam logic OP_CAPTURE = 1'b0;
  localparam logic OP_TICK    = 1'b1;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MOD,
    ST_ANG,
    ST_SPD,
    ST_PUT
  } state_t;

  typedef struct packed {
    logic in_ready;
    logic div_step;
    logic div_last;
    logic out_load;
  } ctl_t;

endpackage
`default_nettype wire

FILE: design/htp_ifs.sv
`default_nettype none
interface htp_in_if;
  logic                        valid;
  logic                        ready;
  logic                        opcode;
  logic [htp_pkg::CAP_W-1:0]   capture_value;

  modport source (output valid, output opcode, output capture_value, input ready);
  modport sink (input valid, input opcode, input capture_value, output ready);
endinterface

interface htp_out_if;
  logic                        valid;
  logic                        ready;
  logic [htp_pkg::CNT_W-1:0]   pulse_count;
  logic [htp_pkg::CAP_W-1:0]   period_ticks;
  logic [htp_pkg::SPD_W-1:0]   speed_rpm_q4;
  logic [htp_pkg::ANG_W-1:0]   angle_deg_q8;
  logic                        stalled;

  modport source (output valid, output pulse_count, output period_ticks,
                  output speed_rpm_q4, output angle_deg_q8, output stalled,
                  input ready);
  modport sink (input valid, input pulse_count, input period_ticks,
                input speed_rpm_q4, input angle_deg_q8, input stalled,
                output ready);
endinterface

interface htp_cfg_if;
  logic                            valid;
  logic                            ready;
  logic [htp_pkg::CFG_IDX_W-1:0]   idx;
  logic [htp_pkg::CFG_DATA_W-1:0]  wdata;

  modport source (output valid, output idx, output wdata, input ready);
  modport sink (input valid, input idx, input wdata, output ready);
endinterface
`default_nettype wire

FILE: design/hall_tachometer_period_capture_core.sv
`default_nettype none
// Hall tachometer with period capture. Each input transfer is either a capture
// event (opcode 0, timer value latched at a hall edge) or a 1 ms tick (opcode 1),
// and yields exactly one result transfer: pulse count, last period, speed in
// Q.4 rpm, angle in Q.8 degrees and the stall flag. One item is processed at a
// time. A single restoring divider, one quotient bit per cycle, is shared by
// the three divisions: position mod pulses_per_rev, angle and speed, run in
// that order between accept and result load; the speed division is skipped
// when speed is known to be zero (stalled or no period yet). The next item is
// accepted as soon as the result sits in the output register, even if the sink
// has not taken it. Configuration writes are always ready and are meant to be
// issued only while the block is idle.
module hall_tachometer_period_capture_core (
  input  wire            clk,
  input  wire            rst_n,
  htp_in_if.sink         in_chan,
  htp_out_if.source      out_chan,
  htp_cfg_if.sink        cfg_chan
);
  import htp_pkg::*;

  // Configuration
  logic [PPR_W-1:0]   ppr_r;
  logic [RLD_W-1:0]   reload_r;
  logic [STALL_W-1:0] stall_ms_r;
  logic [HZ_W-1:0]    hz_r;

  // Tachometer state
  logic [CAP_W-1:0]   prev_cap_r, prev_cap_nxt;
  logic [CAP_W-1:0]   period_r, period_nxt;
  logic [CNT_W-1:0]   edges_r, edges_nxt;
  logic               first_r, first_nxt;
  logic [MS_W-1:0]    ms_r, ms_nxt;
  logic [PPR_W-1:0]   pos_r, pos_nxt;
  logic               is_cap_r;
  logic               stalled_r, stalled_nxt;
  logic [SPD_W-1:0]   speed_r, speed_nxt;
  logic [ANG_W-1:0]   angle_r, angle_nxt;

  // Divider
  logic [DIV_W-1:0]   div_q_r, div_q_nxt, q_step;
  logic [DEN_W-1:0]   div_rem_r, div_rem_nxt, rem_step;
  logic [DEN_W-1:0]   div_d_r, div_d_nxt;
  logic [DCNT_W-1:0]  div_cnt_r, div_cnt_nxt;
  logic [DEN_W:0]     shifted;
  logic [DEN_W:0]     diff;
  logic               ge;

  // Result register
  logic               out_valid_r;
  logic [CNT_W-1:0]   o_cnt_r;
  logic [CAP_W-1:0]   o_period_r;
  logic [SPD_W-1:0]   o_speed_r;
  logic [ANG_W-1:0]   o_angle_r;
  logic               o_stalled_r;

  state_t             state_r, state_nxt;
  ctl_t               ctl;

  logic [PPR_W-1:0]   ppr_eff;
  logic               in_xfer;
  logic               spd_zero;
  logic [PPR_W-1:0]   pos_mod;
  logic [PPR_W:0]     pos_inc;
  logic [PPR_W-1:0]   pos_new;
  logic [PPR_W-1:0]   ang_pos;
  logic [ANUM_W-1:0]  ang_num;
  logic [DIV_W-1:0]   spd_num;
  logic [DEN_W-1:0]   spd_den;

  assign ppr_eff  = (ppr_r == '0) ? PPR_W'(1) : ppr_r;
  assign in_xfer  = in_chan.valid && ctl.in_ready;
  assign spd_zero = stalled_r || (period_r == '0);

  // Next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: if (in_xfer) state_nxt = ST_MOD;
      ST_MOD:  if (div_cnt_r == '0) state_nxt = ST_ANG;
      ST_ANG: begin
        if (div_cnt_r == '0) state_nxt = spd_zero ? ST_PUT : ST_SPD;
      end
      ST_SPD:  if (div_cnt_r == '0) state_nxt = ST_PUT;
      ST_PUT:  if (!out_valid_r || out_chan.ready) state_nxt = ST_IDLE;
      default: state_nxt = ST_IDLE;
    endcase
  end

  // Control outputs
  always_comb begin
    ctl = '0;
    case (state_r)
      ST_IDLE: ctl.in_ready = 1'b1;
      ST_MOD, ST_ANG, ST_SPD: begin
        ctl.div_step = 1'b1;
        ctl.div_last = (div_cnt_r == '0);
      end
      ST_PUT:  ctl.out_load = !out_valid_r || out_chan.ready;
      default: ctl = '0;
    endcase
  end

  // One restoring-division step
  always_comb begin
    shifted  = {div_rem_r, div_q_r[DIV_W-1]};
    diff     = shifted - {1'b0, div_d_r};
    ge       = shifted >= {1'b0, div_d_r};
    rem_step = ge ? diff[DEN_W-1:0] : shifted[DEN_W-1:0];
    q_step   = {div_q_r[DIV_W-2:0], ge};
  end

  // Position update from the reduced position, angle and speed operands
  always_comb begin
    pos_mod = rem_step[PPR_W-1:0];
    pos_inc = {1'b0, pos_mod} + (PPR_W+1)'(1);
    pos_new = (pos_inc >= {1'b0, ppr_eff}) ? '0 : pos_inc[PPR_W-1:0];
    ang_pos = is_cap_r ? pos_new : pos_mod;
    ang_num = ANUM_W'(ang_pos) * ANG_SCALE;
    spd_num = DIV_W'(hz_r) * SPD_SCALE;
    spd_den = DEN_W'(period_r) * DEN_W'(ppr_eff);
  end

  // Datapath next values
  always_comb begin
    prev_cap_nxt = prev_cap_r;
    period_nxt   = period_r;
    edges_nxt    = edges_r;
    first_nxt    = first_r;
    ms_nxt       = ms_r;
    pos_nxt      = pos_r;
    stalled_nxt  = stalled_r;
    speed_nxt    = speed_r;
    angle_nxt    = angle_r;
    div_q_nxt    = div_q_r;
    div_rem_nxt  = div_rem_r;
    div_d_nxt    = div_d_r;
    div_cnt_nxt  = div_cnt_r;

    if (in_xfer) begin
      if (in_chan.opcode == OP_CAPTURE) begin
        if (!first_r) begin
          // wrap correction is exact modulo the capture width
          period_nxt = (in_chan.capture_value >= prev_cap_r) ?
                       in_chan.capture_value - prev_cap_r :
                       reload_r - prev_cap_r + in_chan.capture_value + CAP_W'(1);
        end
        first_nxt    = 1'b0;
        prev_cap_nxt = in_chan.capture_value;
        edges_nxt    = edges_r + CNT_W'(1);
        ms_nxt       = '0;
      end else if (ms_r < MS_MAX) begin
        ms_nxt = ms_r + MS_W'(1);
      end
      stalled_nxt = {1'b0, ms_nxt} > {1'b0, stall_ms_r};
      // start position mod ppr
      div_q_nxt   = {pos_r, {(DIV_W-PPR_W){1'b0}}};
      div_rem_nxt = '0;
      div_d_nxt   = DEN_W'(ppr_eff);
      div_cnt_nxt = DCNT_W'(PPR_W - 1);
    end else if (ctl.div_step) begin
      div_q_nxt   = q_step;
      div_rem_nxt = rem_step;
      div_cnt_nxt = div_cnt_r - DCNT_W'(1);
      if (ctl.div_last) begin
        case (state_r)
          ST_MOD: begin
            if (is_cap_r) pos_nxt = pos_new;
            div_q_nxt   = {ang_num, {(DIV_W-ANUM_W){1'b0}}};
            div_rem_nxt = '0;
            div_cnt_nxt = DCNT_W'(ANUM_W - 1);
          end
          ST_ANG: begin
            angle_nxt   = q_step[ANG_W-1:0];
            speed_nxt   = '0;
            div_q_nxt   = spd_num;
            div_rem_nxt = '0;
            div_d_nxt   = spd_den;
            div_cnt_nxt = DCNT_W'(DIV_W - 1);
          end
          ST_SPD:  speed_nxt = q_step[SPD_W-1:0];
          default: speed_nxt = speed_r;
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= ST_IDLE;
      ppr_r      <= PPR_RST;
      reload_r   <= RLD_RST;
      stall_ms_r <= STALL_RST;
      hz_r       <= HZ_RST;
      prev_cap_r <= '0;
      period_r   <= '0;
      edges_r    <= '0;
      first_r    <= 1'b1;
      ms_r       <= '0;
      pos_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r    <= state_nxt;
      prev_cap_r <= prev_cap_nxt;
      period_r   <= period_nxt;
      edges_r    <= edges_nxt;
      first_r    <= first_nxt;
      ms_r       <= ms_nxt;
      pos_r      <= pos_nxt;
      if (ctl.out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_chan.ready) begin
        out_valid_r <= 1'b0;
      end
      if (cfg_chan.valid) begin
        case (cfg_chan.idx)
          CFG_PPR:   ppr_r      <= cfg_chan.wdata[PPR_W-1:0];
          CFG_RLD:   reload_r   <= cfg_chan.wdata[RLD_W-1:0];
          CFG_STALL: stall_ms_r <= cfg_chan.wdata[STALL_W-1:0];
          CFG_HZ:    hz_r       <= cfg_chan.wdata[HZ_W-1:0];
          default:   hz_r       <= hz_r;
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_xfer) is_cap_r <= (in_chan.opcode == OP_CAPTURE);
    stalled_r <= stalled_nxt;
    speed_r   <= speed_nxt;
    angle_r   <= angle_nxt;
    div_q_r   <= div_q_nxt;
    div_rem_r <= div_rem_nxt;
    div_d_r   <= div_d_nxt;
    div_cnt_r <= div_cnt_nxt;
    if (ctl.out_load) begin
      o_cnt_r     <= edges_r;
      o_period_r  <= period_r;
      o_speed_r   <= speed_r;
      o_angle_r   <= angle_r;
      o_stalled_r <= stalled_r;
    end
  end

  assign in_chan.ready         = ctl.in_ready;
  assign cfg_chan.ready        = 1'b1;
  assign out_chan.valid        = out_valid_r;
  assign out_chan.pulse_count  = o_cnt_r;
  assign out_chan.period_ticks = o_period_r;
  assign out_chan.speed_rpm_q4 = o_speed_r;
  assign out_chan.angle_deg_q8 = o_angle_r;
  assign out_chan.stalled      = o_stalled_r;

endmodule
`default_nettype wire

FILE: design/htp_checker.sv
`default_nettype none
module htp_checker (
  input wire                          clk,
  input wire                          rst_n,
  input wire                          in_valid,
  input wire                          in_ready,
  input wire                          out_valid,
  input wire                          out_ready,
  input wire [htp_pkg::CAP_W-1:0]     period_ticks,
  input wire [htp_pkg::SPD_W-1:0]     speed_rpm_q4,
  input wire [htp_pkg::ANG_W-1:0]     angle_deg_q8,
  input wire                          stalled
);
  import htp_pkg::*;

  localparam logic [ANG_W-1:0] ANG_MAX = ANG_W'(360 * 256 - 1);

  // a result waiting for the sink must hold until transferred
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(speed_rpm_q4) &&
      $stable(angle_deg_q8) && $stable(period_ticks))
    else $error("result changed while waiting for transfer");

  // one item in flight: no accept right after an accept
  a_one_item: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("input accepted while previous item in progress");

  a_stall_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (stalled || period_ticks == '0) |-> speed_rpm_q4 == '0)
    else $error("nonzero speed while stalled or without period");

  a_angle_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> angle_deg_q8 <= ANG_MAX)
    else $error("angle outside one revolution");

endmodule

bind hall_tachometer_period_capture_core htp_checker u_htp_checker (
  .clk          (clk),
  .rst_n        (rst_n),
  .in_valid     (in_chan.valid),
  .in_ready     (in_chan.ready),
  .out_valid    (out_chan.valid),
  .out_ready    (out_chan.ready),
  .period_ticks (out_chan.period_ticks),
  .speed_rpm_q4 (out_chan.speed_rpm_q4),
  .angle_deg_q8 (out_chan.angle_deg_q8),
  .stalled      (out_chan.stalled)
);
`default_nettype wire
